### design/bbd_pkg.sv
// shared types and constants for the bayer bilinear demosaic block
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int FWIDTH_W = 13;
  localparam int FHEIGHT_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic KIND_RAW = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST = 13'd640;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  // bayer phase of the site, {row odd, column odd}
  typedef enum logic [1:0] {
    PH_GREEN_EVEN = 2'b00,
    PH_BLUE       = 2'b01,
    PH_RED        = 2'b10,
    PH_GREEN_ODD  = 2'b11
  } phase_t;

  // one queued operation: shift a sample in, optionally emit a pixel
  typedef struct packed {
    logic                emit;
    logic                row_odd;
    logic                col_odd;
    logic                has_up;
    logic                has_down;
    logic                has_left;
    logic                has_right;
    logic                last_row;
    logic                last_frame;
    logic [SAMPLE_W-1:0] sample;
  } bbd_cmd_t;

endpackage

### design/bbd_if.sv
// channel interfaces of the bayer bilinear demosaic block
`timescale 1ns / 1ps
interface bbd_in_if import bbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface bbd_out_if import bbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red;
  logic [SAMPLE_W-1:0] green;
  logic [SAMPLE_W-1:0] blue;
  logic                end_of_row;
  logic                end_of_frame;
  modport source (output valid, red, green, blue, end_of_row, end_of_frame, input ready);
  modport sink (input valid, red, green, blue, end_of_row, end_of_frame, output ready);
endinterface

interface bbd_cfg_if import bbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/bbd_cmd_fifo.sv
// small command queue between the front and back parts
`timescale 1ns / 1ps
module bbd_cmd_fifo import bbd_pkg::*; #(
  parameter int DW = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full = (count_r == NW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");

endmodule

### design/bbd_front.sv
// front part: config registers, position counters and item classification
`timescale 1ns / 1ps
module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bbd_in_if.sink                       in_ch,
  bbd_cfg_if.sink                      cfg_ch,
  output logic                         push,
  output bbd_cmd_t                     push_cmd,
  output logic [$clog2(MAX_WIDTH)-1:0] push_col,
  input  logic                         q_full
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > FWIDTH_W) ? WW : FWIDTH_W;
  localparam int RW = FHEIGHT_W + 1;

  logic [FWIDTH_W-1:0]  fwidth_r;
  logic [FHEIGHT_W-1:0] fheight_r;
  logic                 dirty_r, dirty_nxt;
  logic [CW-1:0]        icol_r, icol_nxt;
  logic [FHEIGHT_W-1:0] irow_r, irow_nxt;
  logic [CW-1:0]        ocol_r, ocol_nxt;
  logic [FHEIGHT_W-1:0] orow_r, orow_nxt;

  logic [WW-1:0]        w_eff;
  logic [FHEIGHT_W-1:0] h_eff;
  logic                 cfg_fire, in_fire, norm_do, is_raw;
  logic                 clr_in, ready_raw, out_done;
  logic [CW-1:0]        sh_col, e_col;
  logic [FHEIGHT_W-1:0] sh_row, e_row;
  logic [WW-1:0]        sh_inc, e_inc;
  logic                 sh_wrap;
  logic [CW-1:0]        icol_adv, ocol_emit;
  logic [FHEIGHT_W-1:0] irow_adv, orow_emit;
  logic                 has_up, has_down, has_left, has_right, last_row, last_frame;

  // effective frame size
  always_comb begin
    if (fwidth_r == '0) begin
      w_eff = WW'(1);
    end else if (CMPW'(fwidth_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fwidth_r);
    end
  end
  assign h_eff = (fheight_r == '0) ? FHEIGHT_W'(1) : fheight_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire = cfg_ch.valid;
  assign in_ch.ready = !dirty_r && !q_full;
  assign in_fire = in_ch.valid && in_ch.ready;
  // realign counters to the new size before the first item after a write
  assign norm_do = dirty_r && in_ch.valid && !cfg_fire;
  assign dirty_nxt = cfg_fire ? 1'b1 : (norm_do ? 1'b0 : dirty_r);
  assign is_raw = (in_ch.kind == KIND_RAW);

  assign clr_in = (irow_r >= h_eff);
  assign sh_col = (is_raw && clr_in) ? '0 : icol_r;
  assign sh_row = (is_raw && clr_in) ? '0 : irow_r;
  assign e_col = (is_raw && clr_in) ? '0 : ocol_r;
  assign e_row = (is_raw && clr_in) ? '0 : orow_r;

  assign sh_inc = WW'(sh_col) + WW'(1);
  assign sh_wrap = (sh_inc >= w_eff);
  assign icol_adv = sh_wrap ? '0 : CW'(sh_inc);
  assign irow_adv = sh_wrap ? sh_row + FHEIGHT_W'(1) : sh_row;
  assign ready_raw = (sh_row >= FHEIGHT_W'(2)) || ((sh_row == FHEIGHT_W'(1)) && (sh_col != '0));
  assign out_done = (e_row >= h_eff);

  assign e_inc = WW'(e_col) + WW'(1);
  assign has_up = (e_row != '0);
  assign has_down = ((RW'(e_row) + RW'(1)) < RW'(h_eff));
  assign has_left = (e_col != '0);
  assign has_right = (e_inc < w_eff);
  assign last_row = !has_right;
  assign last_frame = last_row && !has_down;
  assign ocol_emit = last_row ? '0 : CW'(e_inc);
  assign orow_emit = last_row ? e_row + FHEIGHT_W'(1) : e_row;

  always_comb begin
    push_cmd.emit = 1'b0;
    push_cmd.row_odd = e_row[0];
    push_cmd.col_odd = e_col[0];
    push_cmd.has_up = has_up;
    push_cmd.has_down = has_down;
    push_cmd.has_left = has_left;
    push_cmd.has_right = has_right;
    push_cmd.last_row = last_row;
    push_cmd.last_frame = last_frame;
    push_cmd.sample = is_raw ? in_ch.sample : '0;
    push_col = sh_col;
    push = 1'b0;
    icol_nxt = icol_r;
    irow_nxt = irow_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (norm_do) begin
      if (WW'(icol_r) >= w_eff) begin
        icol_nxt = '0;
        if (irow_r < h_eff) begin
          irow_nxt = irow_r + FHEIGHT_W'(1);
        end
      end
      if (WW'(ocol_r) >= w_eff) begin
        ocol_nxt = '0;
        if (orow_r != '1) begin
          orow_nxt = orow_r + FHEIGHT_W'(1);
        end
      end
    end else if (in_fire) begin
      if (is_raw) begin
        push = 1'b1;
        push_cmd.emit = ready_raw && !out_done;
        if (!ready_raw) begin
          icol_nxt = icol_adv;
          irow_nxt = irow_adv;
          ocol_nxt = e_col;
          orow_nxt = e_row;
        end else if (out_done || last_frame) begin
          icol_nxt = '0;
          irow_nxt = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else begin
          icol_nxt = icol_adv;
          irow_nxt = irow_adv;
          ocol_nxt = ocol_emit;
          orow_nxt = orow_emit;
        end
      end else if (irow_r >= h_eff) begin
        // drain tick once the whole frame is in
        if (out_done) begin
          icol_nxt = '0;
          irow_nxt = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else begin
          push = 1'b1;
          push_cmd.emit = 1'b1;
          if (last_frame) begin
            icol_nxt = '0;
            irow_nxt = '0;
            ocol_nxt = '0;
            orow_nxt = '0;
          end else begin
            icol_nxt = icol_adv;
            ocol_nxt = ocol_emit;
            orow_nxt = orow_emit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r <= FRAME_WIDTH_RST;
      fheight_r <= FRAME_HEIGHT_RST;
      dirty_r <= 1'b0;
      icol_r <= '0;
      irow_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      dirty_r <= dirty_nxt;
      icol_r <= icol_nxt;
      irow_r <= irow_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_FRAME_WIDTH: fwidth_r <= cfg_ch.data[FWIDTH_W-1:0];
          REG_FRAME_HEIGHT: fheight_r <= cfg_ch.data[FHEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
      (push && push_cmd.emit && push_cmd.last_frame) |=>
      (icol_r == '0 && irow_r == '0 && ocol_r == '0 && orow_r == '0))
    else $error("counters not cleared after last pixel of frame");
  a_no_item_while_dirty: assert property (@(posedge clk) disable iff (!rst_n)
      norm_do |-> !in_fire)
    else $error("item accepted during counter realignment");

endmodule

### design/bbd_back.sv
// back part: line stores, 3x3 window, interpolation and result register
`timescale 1ns / 1ps
module bbd_back import bbd_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  bbd_cmd_t                     q_cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         pop,
  bbd_out_if.source                    out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int SUM_W = 10;
  localparam int CNT_W = 3;
  localparam int PROD_W = 20;
  localparam int RECIP3 = 683;
  localparam int RECIP3_SH = 11;

  function automatic logic [SAMPLE_W-1:0] avg(input logic [SUM_W-1:0] sum,
                                              input logic [CNT_W-1:0] cnt);
    logic [PROD_W-1:0] prod;
    begin
      prod = PROD_W'(sum) * PROD_W'(RECIP3);
      case (cnt)
        3'd1: avg = sum[SAMPLE_W-1:0];
        3'd2: avg = sum[SAMPLE_W:1];
        3'd3: avg = prod[RECIP3_SH+SAMPLE_W-1:RECIP3_SH];
        3'd4: avg = sum[SAMPLE_W+1:2];
        default: avg = '0;
      endcase
    end
  endfunction

  logic [SAMPLE_W-1:0] mem_a [MAX_WIDTH];
  logic [SAMPLE_W-1:0] mem_b [MAX_WIDTH];
  logic [SAMPLE_W-1:0] rd_a_r, rd_b_r;

  logic                adv;
  logic                s1_v_r, s2_v_r, out_valid_r;
  bbd_cmd_t            s1_cmd_r, s2_cmd_r;
  logic [CW-1:0]       s1_col_r;
  logic                fwd_r;
  logic [SAMPLE_W-1:0] fwd_s_r, fwd_a_r;
  logic [SAMPLE_W-1:0] a1_eff, b1_eff;
  logic [SAMPLE_W-1:0] win_r [3][3];

  logic [SUM_W-1:0]    vs, hs, ds, vhs;
  logic [CNT_W-1:0]    vn, hn, dcnt, vhn;
  logic [SAMPLE_W-1:0] mean_v, mean_h, mean_d, mean_vh, ctr;
  logic [SAMPLE_W-1:0] red_c, green_c, blue_c;
  logic [SAMPLE_W-1:0] red_r, green_r, blue_r;
  logic                eor_r, eof_r;

  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && q_valid;

  // same column written the cycle before: take the values being written
  assign a1_eff = fwd_r ? fwd_s_r : rd_a_r;
  assign b1_eff = fwd_r ? fwd_a_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a_r <= mem_a[q_col];
      rd_b_r <= mem_b[q_col];
      if (s1_v_r) begin
        mem_a[s1_col_r] <= s1_cmd_r.sample;
        mem_b[s1_col_r] <= a1_eff;
      end
    end
  end

  // neighbor sums around the window center
  always_comb begin
    vs = (s2_cmd_r.has_up ? SUM_W'(win_r[1][2]) : '0)
       + (s2_cmd_r.has_down ? SUM_W'(win_r[1][0]) : '0);
    vn = CNT_W'(s2_cmd_r.has_up) + CNT_W'(s2_cmd_r.has_down);
    hs = (s2_cmd_r.has_left ? SUM_W'(win_r[2][1]) : '0)
       + (s2_cmd_r.has_right ? SUM_W'(win_r[0][1]) : '0);
    hn = CNT_W'(s2_cmd_r.has_left) + CNT_W'(s2_cmd_r.has_right);
    ds = ((s2_cmd_r.has_up && s2_cmd_r.has_left) ? SUM_W'(win_r[2][2]) : '0)
       + ((s2_cmd_r.has_up && s2_cmd_r.has_right) ? SUM_W'(win_r[0][2]) : '0)
       + ((s2_cmd_r.has_down && s2_cmd_r.has_left) ? SUM_W'(win_r[2][0]) : '0)
       + ((s2_cmd_r.has_down && s2_cmd_r.has_right) ? SUM_W'(win_r[0][0]) : '0);
    dcnt = CNT_W'(s2_cmd_r.has_up && s2_cmd_r.has_left)
         + CNT_W'(s2_cmd_r.has_up && s2_cmd_r.has_right)
         + CNT_W'(s2_cmd_r.has_down && s2_cmd_r.has_left)
         + CNT_W'(s2_cmd_r.has_down && s2_cmd_r.has_right);
    vhs = vs + hs;
    vhn = vn + hn;
    mean_v = avg(vs, vn);
    mean_h = avg(hs, hn);
    mean_d = avg(ds, dcnt);
    mean_vh = avg(vhs, vhn);
    ctr = win_r[1][1];
    case (phase_t'({s2_cmd_r.row_odd, s2_cmd_r.col_odd}))
      PH_GREEN_EVEN: begin
        red_c = mean_v;
        green_c = ctr;
        blue_c = mean_h;
      end
      PH_BLUE: begin
        red_c = mean_d;
        green_c = mean_vh;
        blue_c = ctr;
      end
      PH_RED: begin
        red_c = ctr;
        green_c = mean_vh;
        blue_c = mean_d;
      end
      PH_GREEN_ODD: begin
        red_c = mean_h;
        green_c = ctr;
        blue_c = mean_v;
      end
      default: begin
        red_c = '0;
        green_c = '0;
        blue_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 3; t++) begin
          win_r[k][t] <= '0;
        end
      end
    end else if (adv) begin
      s1_v_r <= pop;
      s2_v_r <= s1_v_r;
      out_valid_r <= s2_v_r && s2_cmd_r.emit;
      fwd_r <= s1_v_r && (s1_col_r == q_col);
      if (s1_v_r) begin
        for (int t = 0; t < 3; t++) begin
          win_r[2][t] <= win_r[1][t];
          win_r[1][t] <= win_r[0][t];
        end
        win_r[0][0] <= s1_cmd_r.sample;
        win_r[0][1] <= a1_eff;
        win_r[0][2] <= b1_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= q_cmd;
      s1_col_r <= q_col;
      s2_cmd_r <= s1_cmd_r;
      fwd_s_r <= s1_cmd_r.sample;
      fwd_a_r <= a1_eff;
      red_r <= red_c;
      green_r <= green_c;
      blue_r <= blue_c;
      eor_r <= s2_cmd_r.last_row;
      eof_r <= s2_cmd_r.last_frame;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue = blue_r;
  assign out_ch.end_of_row = eor_r;
  assign out_ch.end_of_frame = eof_r;

  a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
      (adv && s2_v_r && s2_cmd_r.emit) |=> out_valid_r)
    else $error("pixel lost between window and result register");
  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
      (fwd_r && s1_v_r) |-> $past(s1_v_r))
    else $error("line store forward without a preceding write");

endmodule

### design/bayer_bilinear_demosaic_top.sv
// Bayer GBRG bilinear demosaic, top level
// pixel p comes out on the item that brings sample p + width + 1, or on a drain item
// the result register loads once the item that causes it has passed the command queue and the s1 and s2 stages
// one item per cycle while the result side takes items; the line store port pair sets this
// the first item after a configuration write is held while the counters are realigned to the new size
// synchronous active-low reset clears counters, window, queue and result; line stores keep data
`timescale 1ns / 1ps
module bayer_bilinear_demosaic_top import bbd_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  bbd_in_if.sink     in_ch,
  bbd_cfg_if.sink    cfg_ch,
  bbd_out_if.source  out_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QDEPTH = 4;
  localparam int QDW = $bits(bbd_cmd_t) + CW;

  logic           push, q_full, q_empty, pop;
  bbd_cmd_t       push_cmd, q_cmd;
  logic [CW-1:0]  push_col, q_col;
  logic [QDW-1:0] q_wdata, q_rdata;

  bbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .push_col (push_col),
    .q_full   (q_full)
  );

  assign q_wdata = {push_col, push_cmd};
  assign {q_col, q_cmd} = q_rdata;

  bbd_cmd_fifo #(.DW(QDW), .DEPTH(QDEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  bbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_cmd   (q_cmd),
    .q_col   (q_col),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/tb_bayer_bilinear_demosaic_top.sv
// self-checking testbench for the bayer bilinear demosaic top level
`timescale 1ns / 1ps
module tb_bayer_bilinear_demosaic_top;
  import bbd_pkg::*;

  localparam int ROW_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 650;
  localparam int PRINT_CAP = 100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                eor;
    logic                eof;
  } pixel_t;

  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_TYPED} chk_e;

  typedef struct {
    logic                kind;
    logic [SAMPLE_W-1:0] smp;
    chk_e                chk;
    pixel_t              pix;
  } stim_row_t;

  localparam pixel_t WHITE     = '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0};
  localparam pixel_t WHITE_EOR = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0};
  localparam pixel_t WHITE_EOF = '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};
  localparam pixel_t BLACK     = '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
  localparam pixel_t BLACK_EOR = '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0};

  // 2 x 2 frame: drain before start, white frame, black frame cut short, mixed frame
  stim_row_t plan [23] = '{
    '{KIND_DRAIN, 8'hA5, CHK_NONE,  '0},
    '{KIND_RAW,   8'hFF, CHK_NONE,  '0},
    '{KIND_RAW,   8'hFF, CHK_NONE,  '0},
    '{KIND_RAW,   8'hFF, CHK_NONE,  '0},
    '{KIND_RAW,   8'hFF, CHK_TYPED, WHITE},
    '{KIND_DRAIN, 8'h5A, CHK_TYPED, WHITE_EOR},
    '{KIND_DRAIN, 8'hFF, CHK_TYPED, WHITE},
    '{KIND_DRAIN, 8'h00, CHK_TYPED, WHITE_EOF},
    '{KIND_DRAIN, 8'hC3, CHK_NONE,  '0},
    '{KIND_RAW,   8'h00, CHK_NONE,  '0},
    '{KIND_RAW,   8'h00, CHK_NONE,  '0},
    '{KIND_RAW,   8'h00, CHK_NONE,  '0},
    '{KIND_RAW,   8'h00, CHK_TYPED, BLACK},
    '{KIND_DRAIN, 8'h81, CHK_TYPED, BLACK_EOR},
    '{KIND_DRAIN, 8'h7E, CHK_TYPED, BLACK},
    '{KIND_RAW,   8'h12, CHK_PRED,  '0},
    '{KIND_RAW,   8'hF0, CHK_PRED,  '0},
    '{KIND_RAW,   8'h8D, CHK_PRED,  '0},
    '{KIND_RAW,   8'h3C, CHK_PRED,  '0},
    '{KIND_DRAIN, 8'h00, CHK_PRED,  '0},
    '{KIND_DRAIN, 8'hFF, CHK_PRED,  '0},
    '{KIND_DRAIN, 8'h66, CHK_PRED,  '0},
    '{KIND_DRAIN, 8'h99, CHK_PRED,  '0}
  };

  logic clk;
  logic rst_n;

  bbd_in_if  in_if ();
  bbd_cfg_if cfg_if ();
  bbd_out_if out_if ();

  bayer_bilinear_demosaic_top #(.MAX_WIDTH(ROW_DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  // predictor state
  logic [SAMPLE_W-1:0]  row_hist_near [ROW_DEPTH];
  logic [SAMPLE_W-1:0]  row_hist_far [ROW_DEPTH];
  logic [SAMPLE_W-1:0]  nbhd [3][3];
  int unsigned          in_col, in_line, out_col, out_line;
  logic [FWIDTH_W-1:0]  width_reg;
  logic [FHEIGHT_W-1:0] height_reg;

  pixel_t      expected_pixels [$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned work_items;
  bit          idle_on;
  bit          got_pixel;
  bit          got_eof;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > ROW_DEPTH) w = ROW_DEPTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 1) ? 1 : height_reg;
  endfunction

  function automatic void clear_position();
    in_col = 0;
    in_line = 0;
    out_col = 0;
    out_line = 0;
  endfunction

  function automatic void push_column(input logic [SAMPLE_W-1:0] s, input int unsigned col);
    int unsigned c;
    logic [SAMPLE_W-1:0] a, b;
    c = col % ROW_DEPTH;
    a = row_hist_near[c];
    b = row_hist_far[c];
    row_hist_far[c] = a;
    row_hist_near[c] = s;
    for (int t = 0; t < 3; t++) begin
      nbhd[2][t] = nbhd[1][t];
      nbhd[1][t] = nbhd[0][t];
    end
    nbhd[0][0] = s;
    nbhd[0][1] = a;
    nbhd[0][2] = b;
  endfunction

  function automatic logic [SAMPLE_W-1:0] avg(input int unsigned sum, input int unsigned cnt);
    return (cnt != 0) ? SAMPLE_W'(sum / cnt) : '0;
  endfunction

  function automatic void interpolate(input int unsigned w, input int unsigned h,
                                      output pixel_t px);
    int unsigned r, c, ctr, vs, vn, hs, hn, ds, dc;
    bit up, dn, lf, rt;
    r = out_line;
    c = out_col;
    up = r >= 1;
    dn = r + 1 < h;
    lf = c >= 1;
    rt = c + 1 < w;
    ctr = nbhd[1][1];
    vs = 0; vn = 0; hs = 0; hn = 0; ds = 0; dc = 0;
    if (up) begin vs += nbhd[1][2]; vn++; end
    if (dn) begin vs += nbhd[1][0]; vn++; end
    if (lf) begin hs += nbhd[2][1]; hn++; end
    if (rt) begin hs += nbhd[0][1]; hn++; end
    if (up && lf) begin ds += nbhd[2][2]; dc++; end
    if (up && rt) begin ds += nbhd[0][2]; dc++; end
    if (dn && lf) begin ds += nbhd[2][0]; dc++; end
    if (dn && rt) begin ds += nbhd[0][0]; dc++; end
    case (phase_t'({r[0], c[0]}))
      PH_GREEN_EVEN: begin
        px.red = avg(vs, vn); px.green = ctr[7:0]; px.blue = avg(hs, hn);
      end
      PH_BLUE: begin
        px.red = avg(ds, dc); px.green = avg(vs + hs, vn + hn); px.blue = ctr[7:0];
      end
      PH_RED: begin
        px.red = ctr[7:0]; px.green = avg(vs + hs, vn + hn); px.blue = avg(ds, dc);
      end
      default: begin
        px.red = avg(hs, hn); px.green = ctr[7:0]; px.blue = avg(vs, vn);
      end
    endcase
    px.eor = c + 1 >= w;
    px.eof = px.eor && (r + 1 >= h);
    if (px.eof) clear_position();
    else if (px.eor) begin
      out_col = 0;
      out_line++;
    end else out_col++;
  endfunction

  function automatic bit demosaic_step(input logic kind, input logic [SAMPLE_W-1:0] smp,
                                       output pixel_t px);
    int unsigned w, h;
    bit rdy;
    w = eff_width();
    h = eff_height();
    px = '0;
    if (in_col >= w) begin
      in_col = 0;
      if (in_line < h) in_line++;
    end
    if (out_col >= w) begin
      out_col = 0;
      if (out_line < 16'hFFFF) out_line++;
    end
    if (kind == KIND_RAW) begin
      if (in_line >= h) clear_position();
      rdy = (in_line >= 2) || (in_line == 1 && in_col >= 1);
      push_column(smp, in_col);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_line++;
      end
      if (!rdy) return 1'b0;
      if (out_line >= h) begin
        clear_position();
        return 1'b0;
      end
      interpolate(w, h, px);
      return 1'b1;
    end
    if (in_line < h) return 1'b0;
    if (out_line >= h) begin
      clear_position();
      return 1'b0;
    end
    push_column('0, in_col);
    in_col = (in_col + 1 >= w) ? 0 : in_col + 1;
    interpolate(w, h, px);
    return 1'b1;
  endfunction

  function automatic bit input_complete();
    int unsigned w, h, r;
    w = eff_width();
    h = eff_height();
    r = in_line;
    if (in_col >= w && r < h) r++;
    return r >= h;
  endfunction

  function automatic int unsigned draw_gap();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rnd_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] smp, input chk_e chk,
                           input pixel_t typed);
    int unsigned gap;
    pixel_t px;
    bit hit;
    gap = draw_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.sample <= smp;
    do @(posedge clk); while (!in_if.ready);
    hit = demosaic_step(kind, smp, px);
    got_pixel = hit;
    got_eof = hit && px.eof;
    if (kind == KIND_RAW || hit) work_items++;
    if (chk == CHK_TYPED) expected_pixels.push_back(typed);
    else if (chk == CHK_PRED && hit) expected_pixels.push_back(px);
  endtask

  task automatic send_raw();
    send_item(KIND_RAW, rnd_sample(), CHK_PRED, '0);
  endtask

  task automatic send_drain();
    send_item(KIND_DRAIN, SAMPLE_W'($urandom_range(0, 255)), CHK_PRED, '0);
  endtask

  // raw samples until the frame is in, then drain items until the last pixel is out
  task automatic complete_frame();
    bit done;
    done = 1'b0;
    while (!done) begin
      if (!input_complete()) send_raw();
      else begin
        send_drain();
        done = got_eof || !got_pixel;
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
                           input bit hold);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_FRAME_WIDTH) width_reg = data[FWIDTH_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = data;
    if (!hold) cfg_if.valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_cfg(REG_FRAME_WIDTH, w, 1'b1);
    write_cfg(REG_FRAME_HEIGHT, h, 1'b0);
  endtask

  task automatic note_field(input string name, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want, seen;
    if (rst_n && out_if.valid && out_if.ready) begin
      seen = {out_if.red, out_if.green, out_if.blue, out_if.end_of_row, out_if.end_of_frame};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: unexpected pixel, expected none got r %0d g %0d b %0d eor %0d eof %0d",
                   $time, seen.red, seen.green, seen.blue, seen.eor, seen.eof);
      end else begin
        want = expected_pixels.pop_front();
        note_field("red", want.red, seen.red);
        note_field("green", want.green, seen.green);
        note_field("blue", want.blue, seen.blue);
        note_field("end_of_row", want.eor, seen.eor);
        note_field("end_of_frame", want.eof, seen.eof);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    bit broken;
    logic [CFG_DATA_W-1:0] w_data, h_data;
    in_if.valid <= 1'b0;
    in_if.kind <= KIND_RAW;
    in_if.sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_FRAME_WIDTH;
    cfg_if.data <= '0;
    rst_n <= 1'b0;
    mismatches = 0;
    cycles = 0;
    work_items = 0;
    idle_on = 1'b1;
    broken = 1'b0;
    for (int i = 0; i < ROW_DEPTH; i++) begin
      row_hist_near[i] = '0;
      row_hist_far[i] = '0;
    end
    for (int k = 0; k < 3; k++)
      for (int t = 0; t < 3; t++) nbhd[k][t] = '0;
    clear_position();
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    set_frame(16'd2, 16'd2);
    foreach (plan[i]) send_item(plan[i].kind, plan[i].smp, plan[i].chk, plan[i].pix);
    settle();

    // reset size, cut short by a height change part way into row 1
    set_frame(FRAME_WIDTH_RST, FRAME_HEIGHT_RST);
    repeat (700) send_raw();
    settle();
    set_frame(FRAME_WIDTH_RST, 16'd2);
    complete_frame();
    settle();

    // spare register indexes carry no state
    write_cfg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 65535)), 1'b1);
    write_cfg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 65535)), 1'b0);

    // random small frames
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      if (!broken) begin
        settle();
        case ($urandom_range(0, 9))
          0: w_data = 16'd0;
          1: w_data = 16'd1;
          default: w_data = CFG_DATA_W'($urandom_range(2, 9));
        endcase
        w_data[CFG_DATA_W-1:FWIDTH_W] = $urandom_range(0, 7);
        h_data = ($urandom_range(0, 9) == 0) ? 16'd0 : CFG_DATA_W'($urandom_range(1, 5));
        set_frame(w_data, h_data);
        idle_on = $urandom_range(0, 3) != 0;
      end
      while (!input_complete()) begin
        if ($urandom_range(0, 15) == 0) send_drain();
        send_raw();
      end
      broken = $urandom_range(0, 7) == 0;
      if (broken) begin
        repeat ($urandom_range(0, 3)) send_drain();
      end else begin
        complete_frame();
      end
    end
    settle();

    // widest rows, fills every line store entry
    idle_on = 1'b0;
    set_frame(16'hFFFF, 16'd2);
    complete_frame();
    settle();
    set_frame(16'd4096, 16'd1);
    complete_frame();
    settle();

    // size changes part way into a frame
    idle_on = 1'b1;
    set_frame(16'd6, 16'd4);
    repeat (9) send_raw();
    settle();
    set_frame(16'd3, 16'd4);
    complete_frame();
    settle();
    set_frame(16'd5, 16'd6);
    repeat (13) send_raw();
    settle();
    set_frame(16'd5, 16'd2);
    complete_frame();
    settle();

    // tallest frame, one column
    idle_on = 1'b0;
    set_frame(16'd0, 16'hFFFF);
    complete_frame();
    settle();

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
